// File: sv/tfm_pkg.sv
// Shared types and constants for the timestamp frame matcher.
package tfm_pkg;

  localparam int TABLE_DEPTH = 16;

  localparam logic ACT_PUSH = 1'b0;
  localparam logic ACT_POP  = 1'b1;

  typedef struct packed {
    logic        action;
    logic [63:0] clock_identity;
    logic [15:0] port_number;
    logic [15:0] sequence_number;
    logic [63:0] stamp_in;
  } in_word_t;

  typedef struct packed {
    logic        matched;
    logic [63:0] stamp_out;
    logic        push_dropped;
  } out_word_t;

  typedef struct packed {
    logic [63:0] clock_id;
    logic [15:0] port;
    logic [15:0] seq;
    logic [63:0] stamp;
  } record_t;

  // What a cell hands to its lower neighbor
  typedef struct packed {
    logic    used;
    logic    rm;
    record_t rec;
  } cell_link_t;

  // Broadcast controls from the sequencer to every cell
  typedef struct packed {
    logic    push;
    logic    cmp;
    logic    mark;
    logic    shift;
    record_t key;
  } cell_ctrl_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PUSH,
    ST_CMP,
    ST_MARK,
    ST_SHIFT,
    ST_FIN
  } state_t;

endpackage

// File: sv/tfm_cell.sv
// One table slot: record storage, key compare and shift from upper neighbor.
module tfm_cell
  import tfm_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  cell_ctrl_t ctrl,
  input  logic       prev_used,
  input  cell_link_t nbr,
  input  logic       take,
  input  logic       rm_set,
  output cell_link_t link,
  output logic       eq,
  output logic       lt
);

  logic    used;
  logic    rm;
  record_t rec;
  logic    same;

  assign same = (rec.clock_id == ctrl.key.clock_id) && (rec.port == ctrl.key.port);

  always_ff @(posedge clk) begin
    if (rst) begin
      used <= 1'b0;
      rm   <= 1'b0;
    end else begin
      if (ctrl.push && !used && prev_used) begin
        used <= 1'b1;
      end else if (ctrl.shift && take) begin
        used <= nbr.used;
      end
      if (ctrl.mark) begin
        rm <= rm_set;
      end else if (ctrl.shift && take) begin
        rm <= nbr.rm;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.push && !used && prev_used) begin
      rec <= ctrl.key;
    end else if (ctrl.shift && take) begin
      rec <= nbr.rec;
    end
    if (ctrl.cmp) begin
      eq <= used && same && (rec.seq == ctrl.key.seq);
      lt <= used && same && (rec.seq < ctrl.key.seq);
    end
  end

  assign link = '{used: used, rm: rm, rec: rec};

endmodule

// File: sv/timestamp_frame_matcher.sv
// Top level: sequencer, output register and the row of table cells.
//
// Usage
//   item channel (item_valid/item_ready/item) carries one word per push or
//   pop. result channel (result_valid/result_ready/result) returns one word
//   per item, in order.
//   The table is a row of TABLE_DEPTH cells, oldest record in cell 0.
//   Push writes the first free cell directly (no search); a full table drops
//   the word and flags push_dropped.
//   Pop: the CMP state compares the key in every cell, MARK marks the cells
//   to remove (older sequence numbers of the port up to and including the
//   first equal one) and latches the matched stamp, then each cycle removes
//   the oldest marked cell by shifting every later cell one place down.
// One item is worked on at a time; a pop stays in the removal shift until
//   no marked cell is left.
// item_ready is high only in idle, but a waiting result does not block it:
//   the result sits in its own register and the next item runs until it
//   needs that register.
// Reset empties the table and the result register. A stalled receiver holds
//   the result word stable; processing of a further item pauses at its end.
module timestamp_frame_matcher
  import tfm_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      item_valid,
  output logic      item_ready,
  input  in_word_t  item,
  output logic      result_valid,
  input  logic      result_ready,
  output out_word_t result
);

  state_t state, state_next;

  in_word_t   cur;
  cell_ctrl_t ctrl;
  cell_link_t link [TABLE_DEPTH];
  cell_link_t nbr  [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0] prev_used;
  logic [TABLE_DEPTH-1:0] eq_v;
  logic [TABLE_DEPTH-1:0] lt_v;
  logic [TABLE_DEPTH-1:0] rm_v;
  logic [TABLE_DEPTH-1:0] used_v;
  logic [TABLE_DEPTH-1:0] eq_before;
  logic [TABLE_DEPTH-1:0] first_eq;
  logic [TABLE_DEPTH-1:0] rm_set;
  logic [TABLE_DEPTH-1:0] take;
  logic [63:0]            hit_stamp;

  logic        hit;
  logic [63:0] got;
  logic        dropped;
  logic        accept;
  logic        out_free;

  // Log-depth prefix OR: bit i is the OR of v[0..i]
  function automatic logic [TABLE_DEPTH-1:0] prefix_or(input logic [TABLE_DEPTH-1:0] v);
    logic [TABLE_DEPTH-1:0] p;
    logic [TABLE_DEPTH-1:0] ps;
    p = v;
    for (int d = 1; d < TABLE_DEPTH; d = d * 2) begin
      ps = p;
      for (int i = d; i < TABLE_DEPTH; i++) begin
        p[i] = ps[i] | ps[i-d];
      end
    end
    return p;
  endfunction

  assign item_ready = (state == ST_IDLE);
  assign accept     = item_valid && item_ready;
  assign out_free   = !result_valid || result_ready;

  // Key for compare doubles as push data
  always_comb begin
    ctrl.push           = (state == ST_PUSH);
    ctrl.cmp            = (state == ST_CMP);
    ctrl.mark           = (state == ST_MARK);
    ctrl.shift          = (state == ST_SHIFT);
    ctrl.key.clock_id   = cur.clock_identity;
    ctrl.key.port       = cur.port_number;
    ctrl.key.seq        = cur.sequence_number;
    ctrl.key.stamp      = cur.stamp_in;
  end

  // Cell row
  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    if (i == 0) begin : g_head
      assign prev_used[i] = 1'b1;
    end else begin : g_body
      assign prev_used[i] = link[i-1].used;
    end
    if (i == TABLE_DEPTH - 1) begin : g_tail
      assign nbr[i] = '{used: 1'b0, rm: 1'b0, rec: ctrl.key};
    end else begin : g_mid
      assign nbr[i] = link[i+1];
    end

    assign used_v[i] = link[i].used;
    assign rm_v[i]   = link[i].rm;

    tfm_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .ctrl      (ctrl),
      .prev_used (prev_used[i]),
      .nbr       (nbr[i]),
      .take      (take[i]),
      .rm_set    (rm_set[i]),
      .link      (link[i]),
      .eq        (eq_v[i]),
      .lt        (lt_v[i])
    );
  end

  // Marking: only the first equal record ends the scan
  always_comb begin
    eq_before = prefix_or(eq_v) << 1;
    first_eq  = eq_v & ~eq_before;
    rm_set    = (eq_v | lt_v) & ~eq_before;
    hit_stamp = '0;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      hit_stamp = hit_stamp | ({64{first_eq[i]}} & link[i].rec.stamp);
    end
  end

  // Every cell at or above the oldest marked one pulls from its neighbor
  assign take = prefix_or(rm_v);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          state_next = (item.action == ACT_POP) ? ST_CMP : ST_PUSH;
        end
      end
      ST_PUSH:  state_next = ST_FIN;
      ST_CMP:   state_next = ST_MARK;
      ST_MARK:  state_next = ST_SHIFT;
      ST_SHIFT: begin
        if (!(|rm_v)) begin
          state_next = ST_FIN;
        end
      end
      ST_FIN: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default:  state_next = ST_IDLE;
    endcase
  end

  // Item and pending result registers
  always_ff @(posedge clk) begin
    if (accept) begin
      cur <= item;
    end
    case (state)
      ST_PUSH: begin
        hit     <= 1'b0;
        got     <= '0;
        dropped <= used_v[TABLE_DEPTH-1];
      end
      ST_MARK: begin
        hit     <= |first_eq;
        got     <= hit_stamp;
        dropped <= 1'b0;
      end
      default: begin
      end
    endcase
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (state == ST_FIN && out_free) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_FIN && out_free) begin
      result.matched      <= hit;
      result.stamp_out    <= got;
      result.push_dropped <= dropped;
    end
  end

endmodule

// File: sv/tfm_checker.sv
// Port-level checks for the timestamp frame matcher, bound to the top level.
module tfm_checker
  import tfm_pkg::*;
(
  input logic      clk,
  input logic      rst,
  input logic      item_valid,
  input logic      item_ready,
  input logic      result_valid,
  input logic      result_ready,
  input out_word_t result
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(result))
    else $error("result word changed while stalled");

  a_excl: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> !(result.matched && result.push_dropped))
    else $error("match and drop flagged together");

  a_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result.matched |-> result.stamp_out == '0)
    else $error("stamp without match");

  a_one: assert property (@(posedge clk) disable iff (rst)
    item_valid && item_ready |=> !item_ready ##1 !item_ready)
    else $error("second word taken while first in flight");

endmodule

bind timestamp_frame_matcher tfm_checker u_tfm_checker (
  .clk          (clk),
  .rst          (rst),
  .item_valid   (item_valid),
  .item_ready   (item_ready),
  .result_valid (result_valid),
  .result_ready (result_ready),
  .result       (result)
);
